FILE: hdl/ccns_pkg.sv
// ---------------------------------------------------------------------------
// ccns_pkg
// Shared widths, register indexes and coordinate helpers for the cover-crop
// nearest-neighbor scaler.
// ---------------------------------------------------------------------------
package ccns_pkg;

    // field and arithmetic widths
    localparam int DIM_W      = 10;
    localparam int DEST_Y_W   = 9;
    localparam int FRAC_W     = 16;
    localparam int RATIO_W    = FRAC_W + 2;
    localparam int NUM_W      = DIM_W + FRAC_W;
    localparam int CNT_W      = $clog2(NUM_W);
    localparam int OFF_W      = DIM_W + 2;
    localparam int PROD_W     = OFF_W + RATIO_W + 1;
    localparam int QUO_W      = PROD_W - FRAC_W - 1;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;

    // source dimension limit and ratio constants
    localparam logic [DIM_W-1:0]   MAX_SOURCE_DIM = DIM_W'(640);
    localparam logic [RATIO_W-1:0] RATIO_ONE      = RATIO_W'(1) << FRAC_W;
    localparam logic [RATIO_W-1:0] RATIO_MAX      = '1;

    // register reset values
    localparam logic [DIM_W-1:0]  RST_SOURCE_WIDTH  = DIM_W'(320);
    localparam logic [DIM_W-1:0]  RST_SOURCE_HEIGHT = DIM_W'(240);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE    = 2'd2;

    // frame modes
    localparam logic [MODE_W-1:0] MODE_320X240 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_320X256 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_640X496 = 2'd2;
    localparam logic [MODE_W-1:0] MODE_320X496 = 2'd3;

    // hold a source dimension to 1..MAX_SOURCE_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > MAX_SOURCE_DIM) begin
            r = MAX_SOURCE_DIM;
        end
        return r;
    endfunction

    // target frame width for a mode
    function automatic logic [DIM_W-1:0] mode_width(input logic [MODE_W-1:0] mode);
        logic [DIM_W-1:0] r;
        r = (mode == MODE_640X496) ? DIM_W'(640) : DIM_W'(320);
        return r;
    endfunction

    // target frame height for a mode
    function automatic logic [DIM_W-1:0] mode_height(input logic [MODE_W-1:0] mode);
        logic [DIM_W-1:0] r;
        case (mode)
            MODE_320X240: r = DIM_W'(240);
            MODE_320X256: r = DIM_W'(256);
            MODE_640X496: r = DIM_W'(496);
            MODE_320X496: r = DIM_W'(496);
            default:      r = DIM_W'(496);
        endcase
        return r;
    endfunction

    // floor(s/2 + (d + 0.5 - t/2) * ratio) clamped to 0..s-1
    function automatic logic [DIM_W-1:0] map_coord(
        input logic [DIM_W-1:0]   d,
        input logic [DIM_W-1:0]   t,
        input logic [DIM_W-1:0]   s,
        input logic [RATIO_W-1:0] ratio
    );
        logic signed [OFF_W-1:0]  off;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] base;
        logic signed [PROD_W-1:0] num;
        logic [QUO_W-1:0]         q;
        logic [DIM_W-1:0]         r;
        off  = $signed({1'b0, d, 1'b1}) - $signed({2'b00, t});
        // both operands at full product width before the multiply
        prod = $signed(PROD_W'(off)) * $signed(PROD_W'({1'b0, ratio}));
        base = $signed({{(PROD_W - NUM_W){1'b0}}, s, {FRAC_W{1'b0}}});
        num  = base + prod;
        q    = num[PROD_W-1:FRAC_W+1];
        if (num[PROD_W-1]) begin
            r = '0;
        end else if (q >= QUO_W'(s)) begin
            r = s - DIM_W'(1);
        end else begin
            r = q[DIM_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/ccns_ratio_div.sv
// ---------------------------------------------------------------------------
// ccns_ratio_div
// Bit-serial ratio divider: min(sw/tw, sh/th) in unsigned Q2.16, one
// quotient bit per cycle on both axes at once, saturated to the ratio width.
// ---------------------------------------------------------------------------
module ccns_ratio_div
    import ccns_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIM_W-1:0]   src_w,
    input  logic [DIM_W-1:0]   src_h,
    input  logic [DIM_W-1:0]   tgt_w,
    input  logic [DIM_W-1:0]   tgt_h,
    output logic               busy,
    output logic [RATIO_W-1:0] ratio
);

    logic               busy_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [NUM_W-1:0]   quo_x_reg, quo_y_reg;
    logic [DIM_W-1:0]   rem_x_reg, rem_y_reg;
    logic [DIM_W-1:0]   den_x_reg, den_y_reg;
    logic [RATIO_W-1:0] ratio_reg;

    logic [DIM_W:0]     trial_x, trial_y;
    logic               ge_x, ge_y;
    logic [DIM_W-1:0]   rem_x_next, rem_y_next;
    logic [NUM_W-1:0]   quo_x_next, quo_y_next;
    logic [NUM_W-1:0]   quo_min;
    logic [RATIO_W-1:0] ratio_next;

    // one restoring step per axis
    always_comb begin
        trial_x    = {rem_x_reg, quo_x_reg[NUM_W-1]};
        trial_y    = {rem_y_reg, quo_y_reg[NUM_W-1]};
        ge_x       = trial_x >= {1'b0, den_x_reg};
        ge_y       = trial_y >= {1'b0, den_y_reg};
        rem_x_next = ge_x ? DIM_W'(trial_x - {1'b0, den_x_reg}) : trial_x[DIM_W-1:0];
        rem_y_next = ge_y ? DIM_W'(trial_y - {1'b0, den_y_reg}) : trial_y[DIM_W-1:0];
        quo_x_next = {quo_x_reg[NUM_W-2:0], ge_x};
        quo_y_next = {quo_y_reg[NUM_W-2:0], ge_y};
    end

    // smaller quotient, saturated
    always_comb begin
        quo_min    = (quo_x_next < quo_y_next) ? quo_x_next : quo_y_next;
        ratio_next = (quo_min > NUM_W'(RATIO_MAX)) ? RATIO_MAX : quo_min[RATIO_W-1:0];
    end

    // control and result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            ratio_reg <= RATIO_ONE;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W - 1);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_reg  <= 1'b0;
                ratio_reg <= ratio_next;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_x_reg <= {src_w, {FRAC_W{1'b0}}};
            quo_y_reg <= {src_h, {FRAC_W{1'b0}}};
            rem_x_reg <= '0;
            rem_y_reg <= '0;
            den_x_reg <= tgt_w;
            den_y_reg <= tgt_h;
        end else if (busy_reg) begin
            quo_x_reg <= quo_x_next;
            quo_y_reg <= quo_y_next;
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
        end
    end

    assign busy  = busy_reg;
    assign ratio = ratio_reg;

endmodule

FILE: hdl/cover_crop_nearest_scaler.sv
// ---------------------------------------------------------------------------
// cover_crop_nearest_scaler
// Maps a destination pixel to the source pixel that fills it under
// cover-crop, center-aligned nearest-neighbor scaling.
// ---------------------------------------------------------------------------
//  channel   | direction | carries
//  ----------+-----------+---------------------------------------------
//  s_axis    | in        | dest_x, dest_y request
//  m_axis    | out       | source_x, source_y, beyond_frame flag
//  cfg_wr_*  | in        | source_width, source_height, frame_mode
//
//  one request per cycle while the divider is idle and m_tready keeps up; the
//  result passes the input register, then one multiply-add per axis, into the
//  output register; after a write to source_width, source_height or frame_mode
//  the ratio divider loads, then one quotient bit per cycle; s_tready low meanwhile
//  reset restores 320x240 source, mode 0 and ratio 1.0 with no divide
//  a stalled m_tready holds the result; the input register still fills
// ---------------------------------------------------------------------------
module cover_crop_nearest_scaler
    import ccns_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [DIM_W-1:0]     cfg_wr_data,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // dest_x[9:0], dest_y[18:10], zero pad
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // source_x[9:0], source_y[19:10], zero pad
    output logic [0:0]           m_tuser    // beyond_frame[0]
);

    logic [DIM_W-1:0]    src_w_reg, src_h_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic                start_reg;

    logic                div_busy;
    logic [RATIO_W-1:0]  ratio;
    logic [DIM_W-1:0]    tgt_w, tgt_h;

    logic                v1_reg;
    logic [DIM_W-1:0]    dx1_reg;
    logic [DEST_Y_W-1:0] dy1_reg;

    logic                out_valid_reg;
    logic [DIM_W-1:0]    sx_reg, sy_reg;
    logic                beyond_reg;

    logic                out_ready;
    logic                s_accept;
    logic                beyond_next;
    logic [DIM_W-1:0]    sx_next, sy_next;

    assign tgt_w = mode_width(mode_reg);
    assign tgt_h = mode_height(mode_reg);

    // configuration registers, effective dimensions stored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= RST_SOURCE_WIDTH;
            src_h_reg <= RST_SOURCE_HEIGHT;
            mode_reg  <= MODE_320X240;
            start_reg <= 1'b0;
        end else begin
            start_reg <= cfg_wr_en && ((cfg_wr_index == REG_SOURCE_WIDTH) ||
                                       (cfg_wr_index == REG_SOURCE_HEIGHT) ||
                                       (cfg_wr_index == REG_FRAME_MODE));
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_SOURCE_WIDTH: begin
                        src_w_reg <= eff_dim(cfg_wr_data);
                    end
                    REG_SOURCE_HEIGHT: begin
                        src_h_reg <= eff_dim(cfg_wr_data);
                    end
                    REG_FRAME_MODE: begin
                        mode_reg  <= cfg_wr_data[MODE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // ratio divider
    ccns_ratio_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .src_w   (src_w_reg),
        .src_h   (src_h_reg),
        .tgt_w   (tgt_w),
        .tgt_h   (tgt_h),
        .busy    (div_busy),
        .ratio   (ratio)
    );

    // handshake
    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = (!v1_reg || out_ready) && !div_busy && !start_reg;
    assign s_accept  = s_tvalid && s_tready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_accept) begin
            v1_reg <= 1'b1;
        end else if (out_ready) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            dx1_reg <= s_tdata[DIM_W-1:0];
            dy1_reg <= s_tdata[DIM_W+DEST_Y_W-1:DIM_W];
        end
    end

    // coordinate mapping
    always_comb begin
        beyond_next = (dx1_reg >= tgt_w) || ({1'b0, dy1_reg} >= tgt_h);
        sx_next     = map_coord(dx1_reg, tgt_w, src_w_reg, ratio);
        sy_next     = map_coord({1'b0, dy1_reg}, tgt_h, src_h_reg, ratio);
        if (beyond_next) begin
            sx_next = '0;
            sy_next = '0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && v1_reg) begin
            sx_reg     <= sx_next;
            sy_reg     <= sy_next;
            beyond_reg <= beyond_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, sy_reg, sx_reg};
    assign m_tuser  = beyond_reg;

endmodule

FILE: tb/cover_crop_nearest_scaler_tb.sv
// ---------------------------------------------------------------------------
// cover_crop_nearest_scaler_tb
// Self-checking bench for the cover-crop nearest-neighbor scaler. The
// scoreboard keeps its own copy of the source size, frame mode and scale
// ratio, and predicts the source pixel for each accepted request. Requests
// run under a series of source sizes and frame modes, the extremes among
// them. Both stream sides idle at random, with one phase run at full rate.
// ---------------------------------------------------------------------------
module cover_crop_nearest_scaler_tb
    import ccns_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                   CYCLE_LIMIT = 200000;
    localparam int                   IDLE_PCT    = 37;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;

    // expected source pixel for one request
    typedef struct packed {
        logic [DIM_W-1:0] src_x;
        logic [DIM_W-1:0] src_y;
        logic             beyond;
    } source_pick_t;

    // ---------------------------------------------------------------------
    // scoreboard: own copy of the registers and the scale ratio
    // ---------------------------------------------------------------------
    class source_map_board;
        logic [DIM_W-1:0]  src_w;
        logic [DIM_W-1:0]  src_h;
        logic [MODE_W-1:0] mode;
        longint unsigned   ratio;
        source_pick_t      expected_picks[$];
        int                mismatches;
        int                requests;
        int                results;
        int                beyond_count;

        function new();
            src_w        = RST_SOURCE_WIDTH;
            src_h        = RST_SOURCE_HEIGHT;
            mode         = MODE_320X240;
            mismatches   = 0;
            requests     = 0;
            results      = 0;
            beyond_count = 0;
            update_ratio();
        endfunction

        function int frame_width();
            return (mode == MODE_640X496) ? 640 : 320;
        endfunction

        function int frame_height();
            int h;
            case (mode)
                MODE_320X240: h = 240;
                MODE_320X256: h = 256;
                default:      h = 496;
            endcase
            return h;
        endfunction

        // zero acts as one, oversize held to the maximum
        function longint held_dim(logic [DIM_W-1:0] v);
            longint d;
            d = v;
            if (d < 1) d = 1;
            if (d > 640) d = 640;
            return d;
        endfunction

        // min of both axis ratios, rounded down, saturated to the ratio width
        function void update_ratio();
            longint unsigned rx;
            longint unsigned ry;
            longint unsigned r;
            rx = (held_dim(src_w) << FRAC_W) / frame_width();
            ry = (held_dim(src_h) << FRAC_W) / frame_height();
            r  = (rx < ry) ? rx : ry;
            ratio = (r > ((64'd1 << RATIO_W) - 1)) ? ((64'd1 << RATIO_W) - 1) : r;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
            case (idx)
                REG_SOURCE_WIDTH: begin
                    src_w = val;
                    update_ratio();
                end
                REG_SOURCE_HEIGHT: begin
                    src_h = val;
                    update_ratio();
                end
                REG_FRAME_MODE: begin
                    mode = val[MODE_W-1:0];
                    update_ratio();
                end
                default: ;
            endcase
        endfunction

        // exact in units of 2^-(FRAC_W+1), then clamped to 0..s-1
        function logic [DIM_W-1:0] pick_coord(int d, int t, longint s);
            longint num;
            longint q;
            num = (s << FRAC_W) + (longint'(2 * d + 1) - longint'(t)) * longint'(ratio);
            if (num < 0) return '0;
            q = num >>> (FRAC_W + 1);
            if (q >= s) q = s - 1;
            return DIM_W'(q);
        endfunction

        function void note_request(logic [DIM_W-1:0] dx, logic [DEST_Y_W-1:0] dy);
            source_pick_t p;
            requests++;
            if (dx >= frame_width() || dy >= frame_height()) begin
                p.src_x = '0;
                p.src_y = '0;
                p.beyond = 1'b1;
                beyond_count++;
            end else begin
                p.src_x = pick_coord(dx, frame_width(), held_dim(src_w));
                p.src_y = pick_coord(dy, frame_height(), held_dim(src_h));
                p.beyond = 1'b0;
            end
            expected_picks.push_back(p);
        endfunction

        function void check_result(logic [DIM_W-1:0] sx, logic [DIM_W-1:0] sy,
                                   logic bf);
            source_pick_t p;
            results++;
            if (expected_picks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result x=%0d y=%0d beyond=%0d with none pending",
                             sx, sy, bf);
                return;
            end
            p = expected_picks.pop_front();
            if (sx !== p.src_x || sy !== p.src_y || bf !== p.beyond) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d exp x=%0d y=%0d bf=%0d, got x=%0d y=%0d bf=%0d",
                             results, p.src_x, p.src_y, p.beyond, sx, sy, bf);
            end
        endfunction

        function int pending();
            return expected_picks.size();
        endfunction
    endclass

    // ---------------------------------------------------------------------
    // signals and instance
    // ---------------------------------------------------------------------
    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [DIM_W-1:0]     cfg_wr_data  = '0;
    logic                 s_tvalid     = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata      = '0;   // dest_x[9:0], dest_y[18:10], zero pad
    logic                 m_tvalid;
    logic                 m_tready     = 1'b0;
    logic [23:0]          m_tdata;             // source_x[9:0], source_y[19:10], zero pad
    logic [0:0]           m_tuser;             // beyond_frame[0]

    logic                 calm         = 1'b0;
    int                   cycles       = 0;
    int                   cfg_writes   = 0;
    source_map_board      board        = new();

    cover_crop_nearest_scaler uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // request and result monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_request(s_tdata[9:0], s_tdata[18:10]);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata[9:0], m_tdata[19:10], m_tuser[0]);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // driver tasks
    // ---------------------------------------------------------------------

    // one request, with a random idle gap in front unless running calm
    task automatic send_request(int dx, int dy);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, DEST_Y_W'(dy), DIM_W'(dx)};
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off until every pending result has come back
    // (after first waiting on the clock so the monitor has logged the last request)
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() > 0) @(posedge aclk);
    endtask

    // register write, then wait out the ratio divider
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        board.set_reg(idx, val);
        cfg_writes++;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic configure(int sw, int sh, int mode);
        wait_idle();
        write_reg(REG_SOURCE_WIDTH, DIM_W'(sw));
        write_reg(REG_SOURCE_HEIGHT, DIM_W'(sh));
        write_reg(REG_FRAME_MODE, DIM_W'(mode));
    endtask

    // random coordinate: mostly inside the frame, some at the edges, some anywhere
    function automatic int rand_coord(int limit, int span);
        int r;
        int c;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            c = $urandom_range(0, limit - 1);
        end else if (r < 85) begin
            case ($urandom_range(0, 3))
                0:       c = 0;
                1:       c = limit - 1;
                2:       c = limit;
                default: c = limit + 1;
            endcase
        end else begin
            c = $urandom_range(0, span - 1);
        end
        return c;
    endfunction

    task automatic random_requests(int count);
        for (int i = 0; i < count; i++)
            send_request(rand_coord(board.frame_width(), 1024),
                         rand_coord(board.frame_height(), 512));
    endtask

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset geometry: corners, center and out-of-frame points
        send_request(0, 0);
        send_request(319, 239);
        send_request(320, 239);
        send_request(319, 240);
        send_request(160, 120);
        send_request(1023, 511);
        send_request(0, 511);
        send_request(1023, 0);
        random_requests(140);

        // zero source size acts as one pixel
        configure(0, 0, MODE_320X256);
        send_request(0, 0);
        send_request(319, 255);
        send_request(319, 256);
        random_requests(110);

        // oversize source, widest frame
        configure(1023, 1023, MODE_640X496);
        send_request(0, 0);
        send_request(639, 495);
        send_request(640, 495);
        send_request(639, 496);
        random_requests(140);

        // full-size source at full rate, then a spare index that is ignored
        configure(640, 640, MODE_320X496);
        calm = 1'b1;
        random_requests(150);
        calm = 1'b0;
        wait_idle();
        write_reg(REG_SPARE, '1);
        random_requests(60);

        // one-pixel source on one axis, then a width just past the limit
        configure(1, 640, MODE_320X240);
        random_requests(110);
        configure(640, 1, MODE_640X496);
        random_requests(110);
        configure(641, 479, MODE_320X256);
        random_requests(110);

        // random geometries
        for (int p = 0; p < 5; p++) begin
            configure($urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 3));
            random_requests(110);
        end

        // drain and let the pipeline settle
        wait_idle();
        repeat (10) @(posedge aclk);

        $display("Covered %0d requests (%0d beyond frame), %0d results, %0d register writes",
                 board.requests, board.beyond_count, board.results, cfg_writes);
        $display("Mismatches: %0d, results still pending: %0d",
                 board.mismatches, board.pending());
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
